// ----- design/fpss_pkg.sv -----
package fpss_pkg;

    // Width of the goal and position counters
    localparam int POSITION_BITS = 32;
    localparam int IO_POS_BITS   = 32;
    localparam int STEP_BITS     = 32;
    localparam int EXT_BITS      = 64;

    typedef logic signed [POSITION_BITS-1:0] t_pos;
    typedef logic [1:0]                      t_phase;
    typedef logic [3:0]                      t_coils;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    // Winding patterns, bit0 A .. bit3 D
    localparam t_coils COILS_OFF = 4'h0;
    localparam t_coils COILS_AD  = 4'h9;
    localparam t_coils COILS_CD  = 4'hC;
    localparam t_coils COILS_BC  = 4'h6;
    localparam t_coils COILS_AB  = 4'h3;

    typedef struct packed {
        t_action                        action;
        logic                           direction;
        logic signed [IO_POS_BITS-1:0]  target_position;
        logic                           set_marker;
        logic signed [IO_POS_BITS-1:0]  load_value;
    } t_item;

    function automatic t_coils phase_pattern(input t_phase ph, input logic back);
        t_coils c;
        unique case (ph)
            2'd0:    c = COILS_AD;
            2'd1:    c = back ? COILS_AB : COILS_CD;
            2'd2:    c = COILS_BC;
            default: c = back ? COILS_CD : COILS_AB;
        endcase
        return c;
    endfunction

    // Port value to counter width: sign extend, then keep the low bits
    function automatic t_pos to_pos(input logic signed [IO_POS_BITS-1:0] v);
        logic signed [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v);
        return ext[POSITION_BITS-1:0];
    endfunction

    // Counter to port width: sign extend, then keep the low 32 bits
    function automatic logic signed [IO_POS_BITS-1:0] to_port(input t_pos p);
        logic signed [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(p);
        return ext[IO_POS_BITS-1:0];
    endfunction

endpackage

// ----- design/fpss_in_if.sv -----
interface fpss_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               direction;
    logic signed [31:0] target_position;
    logic               set_marker;
    logic signed [31:0] load_value;

    modport source (
        output valid, action, direction, target_position, set_marker, load_value,
        input  ready
    );
    modport sink (
        input  valid, action, direction, target_position, set_marker, load_value,
        output ready
    );
endinterface

// ----- design/fpss_out_if.sv -----
interface fpss_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         windings;
    logic               moving;
    logic signed [31:0] position;
    logic [31:0]        steps_moved;
    logic               marker;
    logic               target_reached;

    modport source (
        output valid, windings, moving, position, steps_moved, marker, target_reached,
        input  ready
    );
    modport sink (
        input  valid, windings, moving, position, steps_moved, marker, target_reached,
        output ready
    );
endinterface

// ----- design/fpss_in_stage.sv -----
module fpss_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fpss_in_if.sink         i_item,
    input  logic            i_take,
    output logic            o_valid,
    output fpss_pkg::t_item o_item
);
    import fpss_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign i_item.ready = !r_valid || i_take;
    assign accept       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.action          <= t_action'(i_item.action);
            r_item.direction       <= i_item.direction;
            r_item.target_position <= i_item.target_position;
            r_item.set_marker      <= i_item.set_marker;
            r_item.load_value      <= i_item.load_value;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ----- design/fpss_step.sv -----
module fpss_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpss_pkg::t_item i_item,
    output logic            o_take,
    fpss_out_if.source      o_result
);
    import fpss_pkg::*;

    // sequencer state
    t_phase               r_phase,   n_phase;
    logic                 r_running, n_running;
    logic                 r_dir,     n_dir;
    t_pos                 r_goal,    n_goal;
    t_pos                 r_pos,     n_pos;
    logic [STEP_BITS-1:0] r_steps,   n_steps;
    logic                 r_mark,    n_mark;
    t_coils               r_coils,   n_coils;
    logic                 n_reached;

    // result register
    logic                          r_out_valid;
    logic                          r_reached;
    logic signed [IO_POS_BITS-1:0] r_pos_out;

    t_pos step_pos;

    assign o_take   = i_valid && (!r_out_valid || o_result.ready);
    assign step_pos = r_dir ? t_pos'(r_pos - t_pos'(1)) : t_pos'(r_pos + t_pos'(1));

    always_comb begin
        n_phase   = r_phase;
        n_running = r_running;
        n_dir     = r_dir;
        n_goal    = r_goal;
        n_pos     = r_pos;
        n_steps   = r_steps;
        n_mark    = r_mark;
        n_coils   = r_coils;
        n_reached = 1'b0;
        unique case (i_item.action)
            ACT_START: begin
                n_dir     = i_item.direction;
                n_goal    = to_pos(i_item.target_position);
                n_mark    = i_item.set_marker;
                n_running = 1'b1;
            end
            ACT_STOP: begin
                n_running = 1'b0;
            end
            ACT_LOAD: begin
                n_pos = to_pos(i_item.load_value);
            end
            ACT_TICK: begin
                if (!r_running) begin
                    n_coils = COILS_OFF;
                end else begin
                    n_coils = phase_pattern(r_phase, r_dir);
                    n_phase = r_phase + t_phase'(1);
                    n_steps = r_steps + STEP_BITS'(1);
                    n_pos   = step_pos;
                    if (step_pos == r_goal) begin
                        n_running = 1'b0;
                        n_mark    = 1'b0;
                        n_reached = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_running   <= 1'b0;
            r_dir       <= 1'b0;
            r_goal      <= '0;
            r_pos       <= '0;
            r_steps     <= '0;
            r_mark      <= 1'b0;
            r_coils     <= COILS_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_running   <= n_running;
                r_dir       <= n_dir;
                r_goal      <= n_goal;
                r_pos       <= n_pos;
                r_steps     <= n_steps;
                r_mark      <= n_mark;
                r_coils     <= n_coils;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the result; state registers already hold the rest
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_reached <= n_reached;
            r_pos_out <= to_port(n_pos);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.windings       = r_coils;
    assign o_result.moving         = r_running;
    assign o_result.position       = r_pos_out;
    assign o_result.steps_moved    = r_steps;
    assign o_result.marker         = r_mark;
    assign o_result.target_reached = r_reached;
endmodule

// ----- design/four_phase_stepper_sequencer.sv -----
// Throughput: one transaction per cycle while the result is not stalled; input register, then result register;
//   a stalled result blocks the input ready in the same cycle once the input register holds a command.
// Reset: synchronous, active low; phase 0, stopped, forward, goal, position
//   and step count 0, marker clear, all windings off, no result pending.
module four_phase_stepper_sequencer (
    input  logic i_clk,
    input  logic i_rst_n,
    fpss_in_if.sink    i_item,
    fpss_out_if.source o_result
);
    import fpss_pkg::*;

    logic  s1_valid;
    t_item s1_item;
    logic  s1_take;

    // Stage 1: capture the command transaction.
    fpss_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    // Stage 2: apply the command to the sequencer state (start, stop, load,
    // or tick: windings off when stopped, else next two-on pattern, phase
    // advance, step count, position move and goal compare) and register the
    // result transaction. The state updates in the same edge that loads the
    // result, so consecutive commands see each other without bubbles.
    fpss_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_item   (s1_item),
        .o_take   (s1_take),
        .o_result (o_result)
    );
endmodule

// ----- design/fpss_checker.sv -----
module fpss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_windings,
    input logic        i_moving,
    input logic        i_marker,
    input logic        i_target_reached,
    input logic [31:0] i_position,
    input logic [31:0] i_steps_moved
);
    import fpss_pkg::*;

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // reaching the goal stops motion and clears the marker
    a_reach_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_target_reached |-> !i_moving && !i_marker)
        else $error("target reached but still moving or marked");

    // a reaching tick always drives a two-on pattern
    a_reach_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_target_reached |->
            (i_windings == COILS_AD) || (i_windings == COILS_CD) ||
            (i_windings == COILS_BC) || (i_windings == COILS_AB))
        else $error("target reached without a winding pattern");

    // windings are off or a legal two-on pattern
    a_coils_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_windings == COILS_OFF) || (i_windings == COILS_AD) ||
            (i_windings == COILS_CD) || (i_windings == COILS_BC) ||
            (i_windings == COILS_AB))
        else $error("illegal winding pattern");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_windings) &&
            $stable(i_position) && $stable(i_steps_moved) && $stable(i_moving))
        else $error("stalled result changed");
endmodule

bind four_phase_stepper_sequencer fpss_checker u_fpss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_windings       (o_result.windings),
    .i_moving         (o_result.moving),
    .i_marker         (o_result.marker),
    .i_target_reached (o_result.target_reached),
    .i_position       (o_result.position),
    .i_steps_moved    (o_result.steps_moved)
);
